>>> rtl/modexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
// Used by modexp_mulmod and modular_exponentiation; depends on nothing.
package modexp_pkg;

  localparam int MOD_WIDTH   = 31;
  localparam int EXP_WIDTH   = 63;
  localparam int BASE_WIDTH  = 31;
  localparam int POWER_WIDTH = 31;

  localparam int MUL_WIDTH = (MOD_WIDTH > BASE_WIDTH) ? MOD_WIDTH : BASE_WIDTH;
  localparam int CNT_WIDTH = $clog2(MUL_WIDTH + 1);

  localparam int IN_DATA_W  = ((BASE_WIDTH + EXP_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((POWER_WIDTH + 7) / 8) * 8;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-3:0]    REG_MODULUS   = '0;
  localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = MOD_WIDTH'(64'd1000000007);

  typedef struct packed {
    logic                 start;
    logic [MOD_WIDTH-1:0] a;
    logic [MUL_WIDTH-1:0] b;
    logic [MOD_WIDTH-1:0] m;
  } mm_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [MOD_WIDTH-1:0] result;
  } mm_rsp_t;

endpackage

>>> rtl/modular_exponentiation.sv
// Modular exponentiation by square and multiply over a bit-serial modular multiplier.
// The multiplier runs N = max(1, L + P) times (base reduction, squarings, products),
// L = exponent bit length, P = its ones; a modulus below two gives zero without it.
// A new word is taken only in the idle state, after the result is loaded for output.
// Reset (synchronous, active low) clears control and sets the modulus to 1000000007.
// Depends on modexp_pkg and modexp_mulmod.
module modular_exponentiation (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // Fields from bit 0: base (31), exponent (63), zero pad (2).
  input  logic [modexp_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // Fields from bit 0: power (31), zero pad (1).
  output logic [modexp_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [modexp_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [modexp_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [modexp_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                                 cfg_pready
);
  import modexp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RED  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_SQR  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [MOD_WIDTH-1:0]   modulus_r;
  logic [EXP_WIDTH-1:0]   exp_r, exp_nxt;
  logic [MOD_WIDTH-1:0]   sq_r, sq_nxt;
  logic [MOD_WIDTH-1:0]   acc_r, acc_nxt;
  logic                   out_valid_r;
  logic [POWER_WIDTH-1:0] out_data_r;

  logic                   in_accept;
  logic                   cfg_hit;
  logic                   issue;
  logic                   load_out;
  logic [BASE_WIDTH-1:0]  in_base;
  logic [EXP_WIDTH-1:0]   in_exponent;
  mm_req_t                mm_req;
  mm_rsp_t                mm_rsp;

  function automatic state_t next_op(input logic [EXP_WIDTH-1:0] e);
    state_t s;
    if (e == '0) begin
      s = ST_DONE;
    end else if (e[0]) begin
      s = ST_MUL;
    end else begin
      s = ST_SQR;
    end
    return s;
  endfunction

  assign in_base     = in_tdata[BASE_WIDTH-1:0];
  assign in_exponent = in_tdata[BASE_WIDTH +: EXP_WIDTH];
  assign in_tready   = (state_r == ST_IDLE);
  assign in_accept   = in_tvalid && in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_AW-1:2] == REG_MODULUS);
  assign cfg_prdata = cfg_hit ? CFG_DW'(modulus_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      modulus_r <= cfg_pwdata[MOD_WIDTH-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    exp_nxt   = exp_r;
    sq_nxt    = sq_r;
    acc_nxt   = acc_r;
    issue     = 1'b0;
    load_out  = 1'b0;
    mm_req.start = 1'b0;
    mm_req.a     = '0;
    mm_req.b     = '0;
    mm_req.m     = modulus_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          exp_nxt = in_exponent;
          if (modulus_r < MOD_WIDTH'(2)) begin
            acc_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            mm_req.start = 1'b1;
            mm_req.a     = MOD_WIDTH'(1);
            mm_req.b     = MUL_WIDTH'(in_base);
            state_nxt    = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (mm_rsp.done) begin
          sq_nxt    = mm_rsp.result;
          acc_nxt   = MOD_WIDTH'(1);
          state_nxt = next_op(exp_r);
          issue     = 1'b1;
        end
      end
      ST_MUL: begin
        if (mm_rsp.done) begin
          acc_nxt   = mm_rsp.result;
          state_nxt = (exp_r[EXP_WIDTH-1:1] == '0) ? ST_DONE : ST_SQR;
          issue     = 1'b1;
        end
      end
      ST_SQR: begin
        if (mm_rsp.done) begin
          sq_nxt    = mm_rsp.result;
          exp_nxt   = exp_r >> 1;
          state_nxt = next_op(exp_nxt);
          issue     = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (issue && (state_nxt == ST_MUL || state_nxt == ST_SQR)) begin
      mm_req.start = 1'b1;
      mm_req.a     = (state_nxt == ST_MUL) ? acc_nxt : sq_nxt;
      mm_req.b     = MUL_WIDTH'(sq_nxt);
    end
  end

  modexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    exp_r <= exp_nxt;
    sq_r  <= sq_nxt;
    acc_r <= acc_nxt;
    if (load_out) begin
      out_data_r <= POWER_WIDTH'(acc_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

  a_done_in_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> (state_r == ST_RED || state_r == ST_MUL || state_r == ST_SQR))
    else $error("multiplier finished outside an arithmetic state");

  a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mm_rsp.busy)
    else $error("multiplier busy while the sequencer is idle");

  a_small_modulus_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && modulus_r < MOD_WIDTH'(2)) |=> (state_r == ST_DONE && acc_r == '0))
    else $error("modulus below two did not give zero");

  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && modulus_r >= MOD_WIDTH'(2)) |-> (acc_r < modulus_r))
    else $error("result not below the modulus");

endmodule

>>> rtl/modexp_mulmod.sv
// Bit-serial interleaved modular multiplier: result = a * b mod m, a < m.
// One multiplier bit per cycle, MSB first. Depends on modexp_pkg.
module modexp_mulmod (
  input  logic               clk,
  input  logic               rst_n,
  input  modexp_pkg::mm_req_t req,
  output modexp_pkg::mm_rsp_t rsp
);
  import modexp_pkg::*;

  localparam int TW = MOD_WIDTH + 2;

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_WIDTH-1:0] cnt_r;
  logic [MOD_WIDTH-1:0] acc_r;
  logic [MOD_WIDTH-1:0] a_r;
  logic [MOD_WIDTH-1:0] m_r;
  logic [MUL_WIDTH-1:0] b_r;

  logic [TW-1:0]        sum;
  logic [TW-1:0]        m1;
  logic [TW-1:0]        m2;
  logic [TW-1:0]        red;

  // The partial sum stays below 3m, so at most one of m or 2m comes off.
  always_comb begin
    sum = {1'b0, acc_r, 1'b0} + (b_r[MUL_WIDTH-1] ? TW'(a_r) : TW'(0));
    m1  = TW'(m_r);
    m2  = {1'b0, m_r, 1'b0};
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_WIDTH'(MUL_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_WIDTH'(1);
        if (cnt_r == CNT_WIDTH'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      a_r   <= req.a;
      b_r   <= req.b;
      m_r   <= req.m;
    end else if (busy_r) begin
      acc_r <= red[MOD_WIDTH-1:0];
      b_r   <= {b_r[MUL_WIDTH-2:0], 1'b0};
    end
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for modular_exponentiation: streams base and exponent
// words, predicts each power in a scoreboard class and compares it to the result.
// Depends on modexp_pkg and the modular_exponentiation RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import modexp_pkg::*;

  localparam logic [CFG_AW-1:0] MODULUS_ADDR = {REG_MODULUS, 2'b00};
  localparam int HOLD_CYCLES = 3000;

  class power_scoreboard;
    logic [MOD_WIDTH-1:0]   modulus;
    logic [POWER_WIDTH-1:0] expected_powers[$];
    int errors;
    int checked;

    function new();
      modulus = MODULUS_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function logic [POWER_WIDTH-1:0] predict_power(logic [BASE_WIDTH-1:0] base,
                                                   logic [EXP_WIDTH-1:0] exponent);
      logic [63:0] m;
      logic [63:0] sq;
      logic [63:0] acc;
      m = 64'(modulus);
      if (m < 2) return '0;
      sq = 64'(base) % m;
      acc = 64'd1;
      for (int i = 0; i < EXP_WIDTH; i++) begin
        if (exponent[i]) acc = (acc * sq) % m;
        sq = (sq * sq) % m;
      end
      return acc[POWER_WIDTH-1:0];
    endfunction

    function void note_request(logic [BASE_WIDTH-1:0] base, logic [EXP_WIDTH-1:0] exponent);
      expected_powers.push_back(predict_power(base, exponent));
    endfunction

    function void check_power(logic [POWER_WIDTH-1:0] power);
      logic [POWER_WIDTH-1:0] want;
      if (expected_powers.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", power));
        return;
      end
      want = expected_powers.pop_front();
      checked++;
      if (power !== want)
        report($sformatf("power expected %0d, got %0d", want, power));
    endfunction

    function int pending();
      return expected_powers.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_AW-1:0]     cfg_paddr;
  logic [CFG_DW-1:0]     cfg_pwdata;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  power_scoreboard sb;
  bit idle_on;
  bit hold_go;
  bit hold_out;
  int words_sent;
  int phases_run;

  modular_exponentiation DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_power(out_tdata[POWER_WIDTH-1:0]);
  end

  initial begin
    hold_out = 1'b0;
    wait (hold_go);
    @(negedge clk);
    hold_out = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_out = 1'b0;
  end

  initial begin
    int gap;
    gap = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out || !rst_n) begin
        out_tready <= 1'b0;
      end else if (gap > 0) begin
        out_tready <= 1'b0;
        gap--;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
      end
    end
  end

  task automatic send_word(input logic [BASE_WIDTH-1:0] base,
                           input logic [EXP_WIDTH-1:0] exponent);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({exponent, base});
    do @(posedge clk); while (!in_tready);
    sb.note_request(base, exponent);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    logic [63:0] raw;
    logic [EXP_WIDTH-1:0] exponent;
    logic [BASE_WIDTH-1:0] base;
    int len;
    int pick;
    repeat (count) begin
      raw = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 85) len = $urandom_range(0, 12);
      else if (pick < 95) len = $urandom_range(13, 32);
      else len = EXP_WIDTH;
      exponent = EXP_WIDTH'(raw & ((64'd1 << len) - 64'd1));
      pick = $urandom_range(0, 9);
      if (pick < 6) base = BASE_WIDTH'($urandom);
      else if (pick < 8) base = BASE_WIDTH'($urandom_range(0, 3));
      else if (pick < 9) base = sb.modulus + BASE_WIDTH'($urandom_range(0, 2)) - 1'b1;
      else base = '1;
      send_word(base, exponent);
    end
  endtask

  task automatic write_modulus(input logic [MOD_WIDTH-1:0] value);
    logic [CFG_DW-1:0] readback;
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= MODULUS_ADDR;
    cfg_pwdata <= CFG_DW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.modulus = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_psel <= 1'b1;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== CFG_DW'(value))
      sb.report($sformatf("modulus read back %0d, wrote %0d", readback, value));
    phases_run++;
  endtask

  initial begin
    sb = new();
    idle_on = 1'b1;
    hold_go = 1'b0;
    words_sent = 0;
    phases_run = 1;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word('0, '0);
    send_word('0, EXP_WIDTH'(1));
    send_word('0, '1);
    send_word('1, '0);
    send_word('1, EXP_WIDTH'(1));
    send_word('1, '1);
    send_word(BASE_WIDTH'(1), '1);
    send_word(BASE_WIDTH'(2), EXP_WIDTH'(1) << (EXP_WIDTH - 1));
    send_word(BASE_WIDTH'(MODULUS_RESET), EXP_WIDTH'(5));
    send_word(BASE_WIDTH'(MODULUS_RESET) + 1'b1, EXP_WIDTH'(3));
    send_word(BASE_WIDTH'(12345), EXP_WIDTH'(64'h5555_5555_5555_5555));
    send_word(BASE_WIDTH'(7), EXP_WIDTH'(64'h2AAA_AAAA_AAAA_AAAA));
    send_word(BASE_WIDTH'(MODULUS_RESET) - 1'b1, EXP_WIDTH'(2));
    send_random(140);

    write_modulus(MOD_WIDTH'(2));
    send_word('1, '1);
    send_word(BASE_WIDTH'(2), '0);
    send_random(60);

    write_modulus('1);
    hold_go = 1'b1;
    send_word('1, '1);
    send_word('1 - 1'b1, EXP_WIDTH'(2));
    send_random(150);

    write_modulus(MOD_WIDTH'(1));
    send_word(BASE_WIDTH'(5), '0);
    send_word('1, '1);
    send_word('0, '0);
    send_word(BASE_WIDTH'(3), EXP_WIDTH'(7));

    write_modulus('0);
    send_word(BASE_WIDTH'(5), '0);
    send_word('1, '1);
    send_word('0, '0);
    send_word(BASE_WIDTH'(3), EXP_WIDTH'(7));

    write_modulus(MOD_WIDTH'(3));
    idle_on = 1'b0;
    send_random(40);
    idle_on = 1'b1;

    write_modulus(MOD_WIDTH'($urandom_range(2, 255)));
    send_random(80);
    write_modulus(MOD_WIDTH'($urandom_range(256, 32'h7FFF_FFFF)));
    send_random(80);
    write_modulus(MOD_WIDTH'($urandom_range(2, 32'h7FFF_FFFF)));
    send_random(80);

    write_modulus(MODULUS_RESET);
    idle_on = 1'b0;
    send_random(60);
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (50) @(negedge clk);

    $display("Sent %0d words over %0d modulus settings, %0d powers checked, %0d errors.",
             words_sent, phases_run, sb.checked, sb.errors);
    $display("Covered zero and all-ones fields, reduced bases, moduli 0, 1, 2 and 2^31-1.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/modexp_pkg.sv
rtl/modexp_mulmod.sv
rtl/modular_exponentiation.sv
bench/tb_top.sv
